// ----- rtl/dvrt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvrt_pkg
// Shared types and constants of the distance-vector route table.
// ----------------------------------------------------------------------------
package dvrt_pkg;

    localparam int ID_W          = 4;
    localparam int METRIC_W      = 5;
    localparam int NODES_DEFAULT = 16;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [METRIC_W-1:0] INF_METRIC = 5'd16;

    localparam logic [2:0] OP_UPDATE = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_LOOKUP = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic KIND_ANNOUNCE = 1'b0;
    localparam logic KIND_LOOKUP   = 1'b1;

    localparam logic [1:0] ST_LOCAL    = 2'd0;
    localparam logic [1:0] ST_DIRECT   = 2'd1;
    localparam logic [1:0] ST_VIA      = 2'd2;
    localparam logic [1:0] ST_NO_ROUTE = 2'd3;

    typedef enum logic [2:0] {
        CMD_UPDATE,
        CMD_ADD,
        CMD_REMOVE,
        CMD_LOOKUP,
        CMD_CLEAR
    } cmd_kind_t;

    typedef struct packed {
        logic [2:0]          opcode;
        logic [ID_W-1:0]     peer_id;
        logic [ID_W-1:0]     target_id;
        logic [METRIC_W-1:0] metric;
    } in_t;

    typedef struct packed {
        logic                kind;
        logic [ID_W-1:0]     route_dest;
        logic [ID_W-1:0]     hop_id;
        logic [METRIC_W-1:0] route_metric;
        logic [1:0]          lookup_status;
        logic                last;
    } out_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [ID_W-1:0]     peer_id;
        logic [ID_W-1:0]     target_id;
        logic [METRIC_W-1:0] cost;
        logic                tgt_ok;
    } cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]     hop;
        logic [METRIC_W-1:0] cost;
    } entry_t;

endpackage

// ----- rtl/dvrt_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvrt_front
// Input decode: range checks, metric increment, drop of no-op items.
// ----------------------------------------------------------------------------
module dvrt_front #(
    parameter int NODES = dvrt_pkg::NODES_DEFAULT
) (
    input  logic           item_valid,
    input  dvrt_pkg::in_t  item,
    output logic           item_stall,
    input  logic           q_full,
    output logic           push,
    output dvrt_pkg::cmd_t cmd
);

    logic peer_ok;
    logic tgt_ok;
    logic keep;

    assign peer_ok = (32'(item.peer_id) < NODES);
    assign tgt_ok  = (32'(item.target_id) < NODES);

    always_comb
    begin
        cmd.peer_id   = item.peer_id;
        cmd.target_id = item.target_id;
        cmd.tgt_ok    = tgt_ok;
        cmd.cost      = (item.metric >= (dvrt_pkg::INF_METRIC - 5'd1)) ?
                        dvrt_pkg::INF_METRIC : item.metric + 5'd1;
        cmd.kind      = dvrt_pkg::CMD_CLEAR;
        keep          = 1'b0;
        unique case (item.opcode)
            dvrt_pkg::OP_UPDATE:
            begin
                cmd.kind = dvrt_pkg::CMD_UPDATE;
                keep     = peer_ok && tgt_ok;
            end
            dvrt_pkg::OP_ADD:
            begin
                cmd.kind = dvrt_pkg::CMD_ADD;
                keep     = peer_ok;
            end
            dvrt_pkg::OP_REMOVE:
            begin
                cmd.kind = dvrt_pkg::CMD_REMOVE;
                keep     = peer_ok;
            end
            dvrt_pkg::OP_LOOKUP:
            begin
                cmd.kind = dvrt_pkg::CMD_LOOKUP;
                keep     = 1'b1;
            end
            dvrt_pkg::OP_CLEAR:
            begin
                cmd.kind = dvrt_pkg::CMD_CLEAR;
                keep     = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign item_stall = q_full;
    assign push       = item_valid && !q_full && keep;

endmodule

// ----- rtl/dvrt_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvrt_queue
// Short command queue between decode and the table engine.
// ----------------------------------------------------------------------------
module dvrt_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dvrt_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output dvrt_pkg::cmd_t q_cmd
);

    localparam int DEPTH = dvrt_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dvrt_pkg::cmd_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/dvrt_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvrt_engine
// Route table and command sequencer: updates, lookups, clears, neighbor
// changes with full-table announcement scan, and the result register.
// ----------------------------------------------------------------------------
module dvrt_engine #(
    parameter int NODES = dvrt_pkg::NODES_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [dvrt_pkg::ID_W-1:0] self_id,
    input  logic                      q_valid,
    input  dvrt_pkg::cmd_t            q_cmd,
    output logic                      q_pop,
    output logic                      result_valid,
    input  logic                      result_stall,
    output dvrt_pkg::out_t            result
);

    localparam int IW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_UPD  = 4'b0010,
        S_LKP  = 4'b0100,
        S_SCAN = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    logic [NODES-1:0]                valid_reg, valid_next;
    logic [NODES-1:0]                mask_reg, mask_next;
    logic [CW-1:0]                   cnt_reg, cnt_next;
    logic                            kept_reg, kept_next;
    dvrt_pkg::cmd_t                  cmd_reg, cmd_next;

    logic [CW-1:0]                   cur_reg, cur_next;
    logic                            b_valid_reg, b_valid_next;
    logic [IW-1:0]                   b_idx_reg, b_idx_next;
    logic                            b_self_reg, b_self_next;
    logic                            pend_valid_reg, pend_valid_next;
    logic [dvrt_pkg::ID_W-1:0]       pend_dest_reg, pend_dest_next;
    dvrt_pkg::entry_t                pend_reg, pend_next;

    logic                            out_valid_reg;
    dvrt_pkg::out_t                  out_reg;

    dvrt_pkg::entry_t                route_mem [NODES];
    dvrt_pkg::entry_t                rd_reg;
    logic                            mem_we;
    logic [IW-1:0]                   mem_waddr;
    dvrt_pkg::entry_t                mem_wdata;
    logic                            mem_re;
    logic [IW-1:0]                   mem_raddr;

    logic                            emit;
    dvrt_pkg::out_t                  emit_data;
    logic                            out_free;

    logic                            self_ok;
    logic [IW-1:0]                   sidx;
    logic [IW-1:0]                   q_pidx;
    logic [IW-1:0]                   q_tidx;
    logic                            q_peer_self;
    logic [IW-1:0]                   tidx;
    logic                            t_self;
    logic                            t_valid;
    logic [dvrt_pkg::METRIC_W-1:0]   t_cost;
    logic                            take;
    logic [IW-1:0]                   cidx;
    logic                            c_self;
    logic                            c_valid;
    logic                            a_done;
    logic                            scan_adv;

    assign self_ok     = (32'(self_id) < NODES);
    assign sidx        = IW'(self_id);
    assign q_pidx      = IW'(q_cmd.peer_id);
    assign q_tidx      = IW'(q_cmd.target_id);
    assign q_peer_self = kept_reg && self_ok && (sidx == q_pidx);

    assign tidx    = IW'(cmd_reg.target_id);
    assign t_self  = kept_reg && self_ok && (sidx == tidx);
    assign t_valid = t_self || valid_reg[tidx];
    assign t_cost  = t_self ? '0 : rd_reg.cost;
    assign take    = t_valid ? (t_cost > cmd_reg.cost) : (cmd_reg.cost != dvrt_pkg::INF_METRIC);

    assign cidx     = cur_reg[IW-1:0];
    assign c_self   = kept_reg && self_ok && (sidx == cidx);
    assign c_valid  = c_self || valid_reg[cidx];
    assign a_done   = (cur_reg == CW'(NODES));
    assign out_free = !out_valid_reg || !result_stall;
    assign scan_adv = !(b_valid_reg && pend_valid_reg && !out_free);

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        mask_next       = mask_reg;
        cnt_next        = cnt_reg;
        kept_next       = kept_reg;
        cmd_next        = cmd_reg;
        cur_next        = cur_reg;
        b_valid_next    = b_valid_reg;
        b_idx_next      = b_idx_reg;
        b_self_next     = b_self_reg;
        pend_valid_next = pend_valid_reg;
        pend_dest_next  = pend_dest_reg;
        pend_next       = pend_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = q_pidx;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = q_tidx;
        emit            = 1'b0;
        emit_data       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    unique case (q_cmd.kind)
                        dvrt_pkg::CMD_UPDATE:
                        begin
                            if (!mask_reg[q_tidx])
                            begin
                                mem_re     = 1'b1;
                                state_next = S_UPD;
                            end
                        end
                        dvrt_pkg::CMD_LOOKUP:
                        begin
                            mem_re     = 1'b1;
                            state_next = S_LKP;
                        end
                        dvrt_pkg::CMD_ADD:
                        begin
                            mask_next[q_pidx]  = 1'b1;
                            valid_next[q_pidx] = 1'b1;
                            if (!mask_reg[q_pidx])
                            begin
                                cnt_next = cnt_reg + 1'b1;
                            end
                            if (q_peer_self)
                            begin
                                kept_next = 1'b0;
                            end
                            mem_we          = 1'b1;
                            mem_wdata.hop   = q_cmd.peer_id;
                            mem_wdata.cost  = 5'd1;
                            cur_next        = '0;
                            b_valid_next    = 1'b0;
                            pend_valid_next = 1'b0;
                            state_next      = S_SCAN;
                        end
                        dvrt_pkg::CMD_REMOVE:
                        begin
                            mask_next[q_pidx]  = 1'b0;
                            valid_next[q_pidx] = 1'b0;
                            if (mask_reg[q_pidx])
                            begin
                                cnt_next = cnt_reg - 1'b1;
                            end
                            if (q_peer_self)
                            begin
                                kept_next = 1'b0;
                            end
                            if (cnt_next != '0)
                            begin
                                cur_next        = '0;
                                b_valid_next    = 1'b0;
                                pend_valid_next = 1'b0;
                                state_next      = S_SCAN;
                            end
                        end
                        dvrt_pkg::CMD_CLEAR:
                        begin
                            valid_next = '0;
                            kept_next  = 1'b0;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_UPD:
            begin
                if (out_free)
                begin
                    if (take)
                    begin
                        if (t_self)
                        begin
                            kept_next = 1'b0;
                        end
                        valid_next[tidx] = 1'b1;
                        mem_we           = 1'b1;
                        mem_waddr        = tidx;
                        mem_wdata.hop    = cmd_reg.peer_id;
                        mem_wdata.cost   = cmd_reg.cost;
                        if (cnt_reg != '0)
                        begin
                            emit                    = 1'b1;
                            emit_data.kind          = dvrt_pkg::KIND_ANNOUNCE;
                            emit_data.route_dest    = cmd_reg.target_id;
                            emit_data.hop_id        = cmd_reg.peer_id;
                            emit_data.route_metric  = cmd_reg.cost;
                            emit_data.lookup_status = dvrt_pkg::ST_LOCAL;
                            emit_data.last          = 1'b1;
                        end
                    end
                    state_next = S_IDLE;
                end
            end

            S_LKP:
            begin
                if (out_free)
                begin
                    emit                 = 1'b1;
                    emit_data.kind       = dvrt_pkg::KIND_LOOKUP;
                    emit_data.route_dest = cmd_reg.target_id;
                    emit_data.last       = 1'b1;
                    if (!cmd_reg.tgt_ok || !t_valid || (t_cost >= dvrt_pkg::INF_METRIC))
                    begin
                        emit_data.hop_id        = '0;
                        emit_data.route_metric  = dvrt_pkg::INF_METRIC;
                        emit_data.lookup_status = dvrt_pkg::ST_NO_ROUTE;
                    end
                    else if (t_cost == '0)
                    begin
                        emit_data.hop_id        = self_id;
                        emit_data.route_metric  = t_cost;
                        emit_data.lookup_status = dvrt_pkg::ST_LOCAL;
                    end
                    else if (t_cost == 5'd1)
                    begin
                        emit_data.hop_id        = rd_reg.hop;
                        emit_data.route_metric  = t_cost;
                        emit_data.lookup_status = dvrt_pkg::ST_DIRECT;
                    end
                    else
                    begin
                        emit_data.hop_id        = rd_reg.hop;
                        emit_data.route_metric  = t_cost;
                        emit_data.lookup_status = dvrt_pkg::ST_VIA;
                    end
                    state_next = S_IDLE;
                end
            end

            S_SCAN:
            begin
                if (scan_adv)
                begin
                    // read stage: one table entry per cycle while the output does not hold the scan back
                    if (!a_done)
                    begin
                        cur_next     = cur_reg + 1'b1;
                        b_valid_next = c_valid;
                        b_idx_next   = cidx;
                        b_self_next  = c_self;
                        if (c_valid)
                        begin
                            mem_re    = 1'b1;
                            mem_raddr = cidx;
                        end
                    end
                    else
                    begin
                        b_valid_next = 1'b0;
                    end

                    // hold one entry back so the final one can carry last
                    if (b_valid_reg)
                    begin
                        if (pend_valid_reg)
                        begin
                            emit                    = 1'b1;
                            emit_data.kind          = dvrt_pkg::KIND_ANNOUNCE;
                            emit_data.route_dest    = pend_dest_reg;
                            emit_data.hop_id        = pend_reg.hop;
                            emit_data.route_metric  = pend_reg.cost;
                            emit_data.lookup_status = dvrt_pkg::ST_LOCAL;
                            emit_data.last          = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_dest_next  = dvrt_pkg::ID_W'(b_idx_reg);
                        pend_next.hop   = b_self_reg ? self_id : rd_reg.hop;
                        pend_next.cost  = b_self_reg ? '0 : rd_reg.cost;
                    end
                    else if (a_done)
                    begin
                        if (pend_valid_reg)
                        begin
                            if (out_free)
                            begin
                                emit                    = 1'b1;
                                emit_data.kind          = dvrt_pkg::KIND_ANNOUNCE;
                                emit_data.route_dest    = pend_dest_reg;
                                emit_data.hop_id        = pend_reg.hop;
                                emit_data.route_metric  = pend_reg.cost;
                                emit_data.lookup_status = dvrt_pkg::ST_LOCAL;
                                emit_data.last          = 1'b1;
                                pend_valid_next         = 1'b0;
                                state_next              = S_IDLE;
                            end
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            mask_reg       <= '0;
            cnt_reg        <= '0;
            kept_reg       <= 1'b1;
            cur_reg        <= '0;
            b_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            mask_reg       <= mask_next;
            cnt_reg        <= cnt_next;
            kept_reg       <= kept_next;
            cur_reg        <= cur_next;
            b_valid_reg    <= b_valid_next;
            pend_valid_reg <= pend_valid_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        b_idx_reg     <= b_idx_next;
        b_self_reg    <= b_self_next;
        pend_dest_reg <= pend_dest_next;
        pend_reg      <= pend_next;
        if (emit)
        begin
            out_reg <= emit_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            route_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_reg <= route_mem[mem_raddr];
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ----- rtl/distance_vector_route_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_vector_route_table
// Distance-vector routing table of one node: route updates, neighbor
// add/remove with table announcement, lookups and table clear.
//
//   channel  | dir | handshake              | payload
//   ---------+-----+------------------------+------------------------------
//   item     | in  | item_valid/item_stall  | opcode, peer, target, metric
//   result   | out | result_valid/result_stall | kind, dest, hop, metric, status, last
//   config   | in  | APB psel/penable/pready | self_id at address 0 to 3
//
// Update and lookup: the command passes the queue, the table read and the result
// register. Neighbor change: a scan reads one table entry per cycle from the route
// memory, unless the output holds it back, and announces each valid entry. Clear
// acts when the engine takes it from the queue; dropped items end at the transfer.
// A two-entry command queue decouples input from the engine. Reset empties the
// table, neighbor set and queue; self route kept. While a result is held, result
// stall freezes update and lookup, and the scan only when a new result is ready.
// ----------------------------------------------------------------------------
module distance_vector_route_table #(
    parameter int NODES = dvrt_pkg::NODES_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_stall,
    input  dvrt_pkg::in_t  item,
    output logic           result_valid,
    input  logic           result_stall,
    output dvrt_pkg::out_t result,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    logic [dvrt_pkg::ID_W-1:0] self_id_reg;
    logic                      cfg_wr;
    logic                      push;
    dvrt_pkg::cmd_t            push_cmd;
    logic                      q_full;
    logic                      q_pop;
    logic                      q_valid;
    dvrt_pkg::cmd_t            q_cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {28'd0, self_id_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_id_reg <= '0;
        end
        else if (cfg_wr)
        begin
            self_id_reg <= pwdata[dvrt_pkg::ID_W-1:0];
        end
    end

    dvrt_front #(
        .NODES (NODES)
    ) u_front (
        .item_valid (item_valid),
        .item       (item),
        .item_stall (item_stall),
        .q_full     (q_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    dvrt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    dvrt_engine #(
        .NODES (NODES)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .self_id      (self_id_reg),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    a_lookup_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.kind == dvrt_pkg::KIND_LOOKUP) |-> result.last)
        else $error("lookup answer without last");

    a_no_route: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.lookup_status == dvrt_pkg::ST_NO_ROUTE) |->
        (result.route_metric == dvrt_pkg::INF_METRIC) && (result.hop_id == '0))
        else $error("no-route answer with metric or hop set");

    a_announce: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.kind == dvrt_pkg::KIND_ANNOUNCE) |->
        (result.route_metric < dvrt_pkg::INF_METRIC) &&
        (result.lookup_status == dvrt_pkg::ST_LOCAL))
        else $error("announced route unreachable or with status");

endmodule
